>>> hw/rtl/bcpcd_pkg.sv
`default_nettype none

package bcpcd_pkg;

  // fixed sizes of the scan and result fields
  localparam int NumButtons   = 4;
  localparam int CountWidthDef = 17;
  localparam int TickW        = 16;
  localparam int MaskW        = 4;
  localparam int IdW          = 2;
  localparam int CodeW        = 3;
  localparam int CfgIdxW      = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgClick  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPress  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepeat = 2'd2;

  // register reset values
  localparam logic [TickW-1:0] ClickRst  = 16'd2;
  localparam logic [TickW-1:0] PressRst  = 16'd31;
  localparam logic [TickW-1:0] RepeatRst = 16'd33;

  // key bits in keys order
  localparam logic [MaskW-1:0] BitBlue   = 4'h1;
  localparam logic [MaskW-1:0] BitYellow = 4'h2;
  localparam logic [MaskW-1:0] BitRed    = 4'h4;
  localparam logic [MaskW-1:0] BitGreen  = 4'h8;

  // scan order: red, green, yellow, blue
  localparam logic [MaskW-1:0] ScanBits [NumButtons] = '{BitRed, BitGreen, BitYellow, BitBlue};

  // chord codes
  localparam logic [CodeW-1:0] ChordNone        = 3'd0;
  localparam logic [CodeW-1:0] ChordRedGreen    = 3'd1;
  localparam logic [CodeW-1:0] ChordRedYellow   = 3'd2;
  localparam logic [CodeW-1:0] ChordRedBlue     = 3'd3;
  localparam logic [CodeW-1:0] ChordYellowGreen = 3'd4;
  localparam logic [CodeW-1:0] ChordYellowBlue  = 3'd5;
  localparam logic [CodeW-1:0] ChordGreenBlue   = 3'd6;
  localparam logic [CodeW-1:0] ChordMultiRed    = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CLICK = 2'd1,
    PH_PRESS = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    EV_CLICK = 2'd0,
    EV_PRESS = 2'd1,
    EV_CHORD = 2'd2
  } kind_e;

  typedef struct packed {
    logic [TickW-1:0] click;
    logic [TickW-1:0] press;
    logic [TickW-1:0] repeat_t;
  } ticks_t;

  typedef struct packed {
    logic [MaskW-1:0] pressed;
    logic [MaskW-1:0] chord;
  } masks_t;

  typedef struct packed {
    logic             vld;
    kind_e            kind;
    logic [MaskW-1:0] mask;
    logic [CodeW-1:0] code;
  } evt_t;

  // chord classification of a held-together mask
  function automatic logic [CodeW-1:0] classify(input logic [MaskW-1:0] m);
    logic [CodeW-1:0] c;
    unique case (m)
      BitRed | BitGreen:                     c = ChordRedGreen;
      BitRed | BitYellow:                    c = ChordRedYellow;
      BitRed | BitBlue:                      c = ChordRedBlue;
      BitYellow | BitGreen:                  c = ChordYellowGreen;
      BitYellow | BitBlue:                   c = ChordYellowBlue;
      BitGreen | BitBlue:                    c = ChordGreenBlue;
      BitYellow | BitGreen | BitRed:         c = ChordMultiRed;
      BitYellow | BitBlue | BitRed:          c = ChordMultiRed;
      BitGreen | BitBlue | BitRed:           c = ChordMultiRed;
      BitYellow | BitGreen | BitBlue | BitRed: c = ChordMultiRed;
      default:                               c = ChordNone;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bcpcd_cell.sv
`default_nettype none

module bcpcd_cell import bcpcd_pkg::*; #(
  parameter int CountWidth = CountWidthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             held_i,
  input  wire logic [MaskW-1:0] bit_i,
  input  wire ticks_t           ticks_i,
  input  wire masks_t           masks_i,
  output masks_t                masks_o,
  output evt_t                  evt_o
);

  localparam int CmpW = (CountWidth > TickW) ? CountWidth : TickW;

  phase_e                phase_q, phase_d;
  logic [CountWidth-1:0] count_q, count_d;

  // next phase, count, shared masks and event of this button
  always_comb begin
    logic [CountWidth-1:0] bumped;
    logic [CmpW-1:0]       old_w;
    logic [MaskW-1:0]      pressed_n;
    bumped    = (count_q == {CountWidth{1'b1}}) ? count_q : count_q + 1'b1;
    old_w     = CmpW'(count_q);
    pressed_n = masks_i.pressed;
    phase_d   = phase_q;
    count_d   = count_q;
    masks_o   = masks_i;
    evt_o     = '{vld: 1'b0, kind: EV_CLICK, mask: bit_i, code: ChordNone};
    unique case (phase_q)
      PH_IDLE: begin
        if (held_i) begin
          count_d = bumped;
          if (old_w > CmpW'(ticks_i.click)) begin
            phase_d         = PH_CLICK;
            pressed_n       = masks_i.pressed | bit_i;
            masks_o.pressed = pressed_n;
            masks_o.chord   = masks_i.chord | pressed_n;
          end
        end else begin
          count_d = '0;
        end
      end
      PH_CLICK, PH_PRESS: begin
        if (held_i) begin
          count_d = bumped;
          if (phase_q == PH_CLICK) begin
            if (old_w > CmpW'(ticks_i.press)) phase_d = PH_PRESS;
          end else if (old_w > CmpW'(ticks_i.repeat_t)) begin
            count_d = CountWidth'(ticks_i.press);
            if (masks_i.chord == bit_i) begin
              evt_o.vld  = 1'b1;
              evt_o.kind = EV_PRESS;
            end
          end
        end else begin
          phase_d         = PH_IDLE;
          pressed_n       = masks_i.pressed & ~bit_i;
          masks_o.pressed = pressed_n;
          if (masks_i.chord != bit_i) begin
            if (pressed_n == '0) begin
              evt_o.vld  = 1'b1;
              evt_o.kind = EV_CHORD;
              evt_o.mask = masks_i.chord;
              evt_o.code = classify(masks_i.chord);
            end
          end else begin
            masks_o.chord = '0;
            if (phase_q == PH_CLICK) begin
              evt_o.vld  = 1'b1;
              evt_o.kind = EV_CLICK;
            end
          end
        end
      end
      default: begin
        // unreachable phase code holds still
      end
    endcase
  end

  // phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/button_click_press_chord_detector.sv
// Four-button click / long-press / chord detector.
// Input channel: in_valid_i, in_stall_o, keys_i. One item is one finished scan
// of the four buttons, taken when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o, out_stall_i and the event fields. A scan gives
// zero to four events, in button order red, green, yellow, blue; last_o marks
// the final event of a scan.
// The four buttons sit in a row of cells that pass the shared pressed and
// chord masks along combinationally, so a scan is absorbed in the cycle it is
// accepted. Its events wait in a four-slot pending buffer, then move one per
// cycle, while the receiver does not stall, into the output register.
// The single output register drains the buffer one event at a time, and the
// input stalls while events other than the one moving out are pending.
// A new scan is taken while the last pending event moves out, and while an
// event sits stalled in the output register with the pending buffer empty.
// When the receiver stalls, the output register and pending buffer hold and
// the input stalls once the buffer cannot empty.
// Reset clears all phases, counts and masks, empties the buffers and loads the
// tick registers with 2, 31 and 33. Write registers only while idle.
`default_nettype none

module button_click_press_chord_detector import bcpcd_pkg::*; #(
  parameter int CountWidth = CountWidthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [TickW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [MaskW-1:0]   keys_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [IdW-1:0]          button_id_o,
  output logic [1:0]              event_kind_o,
  output logic [MaskW-1:0]        chord_mask_o,
  output logic [CodeW-1:0]        chord_code_o,
  output logic                    last_o
);

  ticks_t                ticks_q;
  masks_t                masks_q, masks_d;
  masks_t                chain [NumButtons+1];
  evt_t                  evts [NumButtons];
  evt_t                  pend_q [NumButtons];
  logic [NumButtons-1:0] pend_vld_q, pend_vld_d;
  logic [NumButtons-1:0] sel_oh, pend_rest;
  logic [IdW-1:0]        sel;
  logic                  in_acc, out_free, move;
  logic                  out_valid_q;
  logic [IdW-1:0]        out_id_q;
  kind_e                 out_kind_q;
  logic [MaskW-1:0]      out_mask_q;
  logic [CodeW-1:0]      out_code_q;
  logic                  out_last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= '{click: ClickRst, press: PressRst, repeat_t: RepeatRst};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgClick:  ticks_q.click    <= cfg_data_i;
        CfgPress:  ticks_q.press    <= cfg_data_i;
        CfgRepeat: ticks_q.repeat_t <= cfg_data_i;
        default:   ticks_q          <= ticks_q;
      endcase
    end
  end

  // row of button cells in scan order
  assign chain[0] = masks_q;

  for (genvar g = 0; g < NumButtons; g++) begin : g_cell
    bcpcd_cell #(
      .CountWidth(CountWidth)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (in_acc),
      .held_i  ((keys_i & ScanBits[g]) != '0),
      .bit_i   (ScanBits[g]),
      .ticks_i (ticks_q),
      .masks_i (chain[g]),
      .masks_o (chain[g+1]),
      .evt_o   (evts[g])
    );
  end

  // chord mask clears once every button is up
  always_comb begin
    masks_d = chain[NumButtons];
    if (chain[NumButtons].pressed == '0) masks_d.chord = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      masks_q <= '0;
    end else if (in_acc) begin
      masks_q <= masks_d;
    end
  end

  // lowest pending slot goes out next
  always_comb begin
    sel    = '0;
    sel_oh = '0;
    for (int i = NumButtons - 1; i >= 0; i--) begin
      if (pend_vld_q[i]) begin
        sel    = IdW'(i);
        sel_oh = NumButtons'(1) << i;
      end
    end
  end

  assign pend_rest  = pend_vld_q & ~sel_oh;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign move       = (pend_vld_q != '0) && out_free;
  assign in_stall_o = (pend_vld_q != '0) && !(move && pend_rest == '0);
  assign in_acc     = in_valid_i && !in_stall_o;

  // pending valid bits
  always_comb begin
    if (in_acc) begin
      for (int i = 0; i < NumButtons; i++) pend_vld_d[i] = evts[i].vld;
    end else if (move) begin
      pend_vld_d = pend_rest;
    end else begin
      pend_vld_d = pend_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= '0;
    end else begin
      pend_vld_q <= pend_vld_d;
    end
  end

  // pending event payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < NumButtons; i++) pend_q[i] <= evts[i];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_id_q   <= sel;
      out_kind_q <= pend_q[sel].kind;
      out_mask_q <= pend_q[sel].mask;
      out_code_q <= pend_q[sel].code;
      out_last_q <= (pend_rest == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign button_id_o  = out_id_q;
  assign event_kind_o = out_kind_q;
  assign chord_mask_o = out_mask_q;
  assign chord_code_o = out_code_q;
  assign last_o       = out_last_q;

  // every pressed button is part of the held-together mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (masks_q.pressed & ~masks_q.chord) == '0)
    else $error("pressed mask not covered by chord mask");

  // while events are pending, the output register holds a valid event next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_vld_q != '0) |=> out_valid_o)
    else $error("pending event not moved to output");

  // a non-final event always has its successors pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (pend_vld_q != '0))
    else $error("scan events lost before last");

endmodule

`default_nettype wire
